FILE: rtl/afbc_pkg.sv
// Shared types and codes for the ALU with flags and branch condition block.
package afbc_pkg;

  localparam int DataWidth = 32;
  localparam int ShiftBits = 5;

  // Command codes
  localparam logic CMD_ALU  = 1'b0;
  localparam logic CMD_COND = 1'b1;

  // ALU operation codes
  localparam logic [2:0] OP_ADD   = 3'd0;
  localparam logic [2:0] OP_ADDC  = 3'd1;
  localparam logic [2:0] OP_SUB   = 3'd2;
  localparam logic [2:0] OP_SUBB  = 3'd3;
  localparam logic [2:0] OP_AND   = 3'd4;
  localparam logic [2:0] OP_OR    = 3'd5;
  localparam logic [2:0] OP_XOR   = 3'd6;
  localparam logic [2:0] OP_SHIFT = 3'd7;

  // Branch condition codes
  localparam logic [2:0] CC_ALWAYS = 3'd0;
  localparam logic [2:0] CC_HI     = 3'd1;
  localparam logic [2:0] CC_NC     = 3'd2;
  localparam logic [2:0] CC_NZ     = 3'd3;
  localparam logic [2:0] CC_NV     = 3'd4;
  localparam logic [2:0] CC_NN     = 3'd5;
  localparam logic [2:0] CC_GE     = 3'd6;
  localparam logic [2:0] CC_GT     = 3'd7;

  // Bit positions in the flag vector
  localparam int FLAG_Z = 3;
  localparam int FLAG_V = 2;
  localparam int FLAG_N = 1;
  localparam int FLAG_C = 0;

  typedef struct packed {
    logic                 command;
    logic [2:0]           alu_op;
    logic [DataWidth-1:0] operand_a;
    logic [DataWidth-1:0] operand_b;
    logic                 set_flags;
    logic [2:0]           condition_code;
    logic                 invert_condition;
  } req_t;

  typedef struct packed {
    logic [DataWidth-1:0] result;
    logic                 branch_taken;
    logic                 shift_range_error;
    logic [3:0]           flags_now;
  } rsp_t;

endpackage

FILE: rtl/alu_flags_branch_condition.sv
// Top level: 32-bit ALU with Z/V/N/C flag register and branch condition test.
//
// Usage:
//   Request channel (req_valid/req_ready/req) carries one item: either an ALU
//   operation (add, addc, sub, subb, and, or, xor, signed-amount shift) or a
//   branch condition test against the current flags.
//   Response channel (rsp_valid/rsp_ready/rsp) returns exactly one item per
//   request: result, branch outcome, shift range error and the flags after
//   the item.
// Timing:
//   An accepted item is held in the input register, then the ALU and flag
//   logic fill the response register, which raises rsp_valid. Throughput is
//   one item per cycle while rsp_ready does not stall the output; the flag
//   register is written in the same edge that loads the response register,
//   so the next item already sees the new flags.
// Reset:
//   rst (synchronous, active high) empties both registers and clears all
//   four flags.
// Stall:
//   While rsp_valid is high and rsp_ready low, the response holds and the
//   input register holds its item; req_ready stays high while the input
//   register is empty, so one more item can be taken during a stall.
module alu_flags_branch_condition
  import afbc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  logic                 s1_valid;
  req_t                 s1_req;
  logic [3:0]           flags;
  logic [3:0]           flags_next;
  rsp_t                 rsp_next;
  logic                 advance;

  logic [DataWidth-1:0] b_mod;
  logic                 cin;
  logic [DataWidth:0]   sum;
  logic                 add_ovf;
  logic                 amt_pos_ok;
  logic                 amt_neg_ok;
  logic                 shift_err;
  logic [ShiftBits-1:0] right_amt;
  logic [DataWidth:0]   left_wide;
  logic [DataWidth-1:0] alu_res;
  logic                 alu_cout;
  logic                 alu_ovf;
  logic                 cond;

  // Move response along when the output is free or being taken
  assign advance   = !rsp_valid || rsp_ready;
  assign req_ready = !s1_valid || advance;

  // Adder: a + b' + cin
  always_comb begin
    b_mod = (s1_req.alu_op == OP_SUB || s1_req.alu_op == OP_SUBB) ?
            ~s1_req.operand_b : s1_req.operand_b;
    case (s1_req.alu_op)
      OP_ADDC: cin = flags[FLAG_C];
      OP_SUB:  cin = 1'b1;
      OP_SUBB: cin = !flags[FLAG_C];
      default: cin = 1'b0;
    endcase
    sum = {1'b0, s1_req.operand_a} + {1'b0, b_mod} + {{DataWidth{1'b0}}, cin};
    add_ovf = (s1_req.operand_a[DataWidth-1] == b_mod[DataWidth-1]) &&
              (s1_req.operand_a[DataWidth-1] != sum[DataWidth-1]);
  end

  // Shifter: range check on the signed amount, left with carry, right logical
  always_comb begin
    amt_pos_ok = (s1_req.operand_b[DataWidth-1:ShiftBits] == '0);
    amt_neg_ok = (s1_req.operand_b[DataWidth-1:ShiftBits] == '1) &&
                 (s1_req.operand_b[ShiftBits-1:0] != '0);
    shift_err  = !(amt_pos_ok || amt_neg_ok);
    right_amt  = ~s1_req.operand_b[ShiftBits-1:0] + ShiftBits'(1);
    left_wide  = {1'b0, s1_req.operand_a} << s1_req.operand_b[ShiftBits-1:0];
  end

  // Select operation result
  always_comb begin
    alu_res  = '0;
    alu_cout = 1'b0;
    alu_ovf  = 1'b0;
    case (s1_req.alu_op)
      OP_ADD, OP_ADDC, OP_SUB, OP_SUBB: begin
        alu_res  = sum[DataWidth-1:0];
        alu_cout = sum[DataWidth];
        alu_ovf  = add_ovf;
      end
      OP_AND: alu_res = s1_req.operand_a & s1_req.operand_b;
      OP_OR:  alu_res = s1_req.operand_a | s1_req.operand_b;
      OP_XOR: alu_res = s1_req.operand_a ^ s1_req.operand_b;
      OP_SHIFT: begin
        if (shift_err) begin
          alu_res = '0;
        end else if (!s1_req.operand_b[DataWidth-1]) begin
          alu_res  = left_wide[DataWidth-1:0];
          alu_cout = left_wide[DataWidth];
        end else begin
          alu_res = s1_req.operand_a >> right_amt;
        end
      end
      default: alu_res = '0;
    endcase
  end

  // Evaluate branch condition on current flags
  always_comb begin
    case (s1_req.condition_code)
      CC_ALWAYS: cond = 1'b1;
      CC_HI:     cond = flags[FLAG_C] && !flags[FLAG_Z];
      CC_NC:     cond = !flags[FLAG_C];
      CC_NZ:     cond = !flags[FLAG_Z];
      CC_NV:     cond = !flags[FLAG_V];
      CC_NN:     cond = !flags[FLAG_N];
      CC_GE:     cond = (flags[FLAG_N] == flags[FLAG_V]);
      CC_GT:     cond = !flags[FLAG_Z] && (flags[FLAG_N] == flags[FLAG_V]);
      default:   cond = 1'b0;
    endcase
  end

  // Build next flags and response
  always_comb begin
    flags_next = flags;
    rsp_next   = '0;
    if (s1_req.command == CMD_COND) begin
      rsp_next.branch_taken = cond ^ s1_req.invert_condition;
    end else begin
      rsp_next.result = alu_res;
      rsp_next.shift_range_error = (s1_req.alu_op == OP_SHIFT) && shift_err;
      if (s1_req.set_flags && !rsp_next.shift_range_error) begin
        // subtract with borrow only ever clears zero
        if (s1_req.alu_op != OP_SUBB || flags[FLAG_Z]) begin
          flags_next[FLAG_Z] = (alu_res == '0);
        end
        flags_next[FLAG_N] = alu_res[DataWidth-1];
        flags_next[FLAG_V] = alu_ovf;
        flags_next[FLAG_C] = alu_cout;
      end
    end
    rsp_next.flags_now = flags_next;
  end

  // Control registers: input stage, output stage, flags
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      rsp_valid <= 1'b0;
      flags     <= '0;
    end else begin
      if (req_ready) begin
        s1_valid <= req_valid;
      end
      if (advance) begin
        rsp_valid <= s1_valid;
      end
      if (advance && s1_valid) begin
        flags <= flags_next;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      s1_req <= req;
    end
    if (advance && s1_valid) begin
      rsp <= rsp_next;
    end
  end

endmodule

FILE: rtl/afbc_checker.sv
// Port-level checks for the ALU with flags and branch condition block.
module afbc_checker
  import afbc_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic req_ready,
  input logic rsp_valid,
  input logic rsp_ready,
  input rsp_t rsp
);

  // Response register is empty right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("rsp_valid high after reset");

  // Stalled response holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("response changed under stall");

  // Input is open whenever the response register is empty
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !rsp_valid |-> req_ready)
    else $error("req_ready low with empty response register");

  // A shift range error gives a zero result and no branch outcome
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.shift_range_error |-> rsp.result == '0 && !rsp.branch_taken)
    else $error("range error with nonzero result or branch");

  // A taken branch comes from a condition item, which has no result
  a_taken_clean: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.branch_taken |-> rsp.result == '0 && !rsp.shift_range_error)
    else $error("branch taken with ALU result fields");

endmodule

bind alu_flags_branch_condition afbc_checker u_afbc_checker (
  .clk       (clk),
  .rst       (rst),
  .req_ready (req_ready),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);

FILE: tb/alu_flags_branch_condition_checker.sv
// Checker for the ALU flag block: predicts every accepted item and compares responses.
module alu_flags_branch_condition_checker
  import afbc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  input  logic req_ready,
  input  req_t req,
  input  logic rsp_valid,
  input  logic rsp_ready,
  input  rsp_t rsp,
  output int   fail_count,
  output int   outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ShiftLimit = 31;

  // Flag register copy: zero, negative, overflow, carry
  logic zf = 1'b0;
  logic nf = 1'b0;
  logic vf = 1'b0;
  logic cf = 1'b0;

  rsp_t expected_rsp_q[$];
  rsp_t want;
  int   rsp_index = 0;

  initial begin
    fail_count  = 0;
    outstanding = 0;
  end

  // Print one line per failure and count it
  task automatic report_failure(input string msg);
    $display("[%0t] %s", $realtime, msg);
    fail_count++;
  endtask

  // Evaluate a branch condition against the current flags
  function automatic logic cond_holds(input logic [2:0] code, input logic inv);
    logic t;
    t = 1'b0;
    case (code)
      CC_ALWAYS: t = 1'b1;
      CC_HI:     t = cf && !zf;
      CC_NC:     t = !cf;
      CC_NZ:     t = !zf;
      CC_NV:     t = !vf;
      CC_NN:     t = !nf;
      CC_GE:     t = (nf == vf);
      CC_GT:     t = !zf && (nf == vf);
      default:   t = 1'b0;
    endcase
    return inv ? !t : t;
  endfunction

  // Compute the response of one item and advance the flag copy
  function automatic rsp_t alu_predict(input req_t r);
    rsp_t        o;
    logic [31:0] bm;
    logic [31:0] res;
    logic [32:0] sum;
    logic [63:0] wide;
    logic        cin;
    logic        cout;
    logic        ovf;
    logic        err;
    int          amt;
    o    = '0;
    res  = '0;
    cout = 1'b0;
    ovf  = 1'b0;
    err  = 1'b0;
    if (r.command == CMD_COND) begin
      o.branch_taken = cond_holds(r.condition_code, r.invert_condition);
    end else begin
      case (r.alu_op)
        OP_ADD, OP_ADDC, OP_SUB, OP_SUBB: begin
          // Subtract is add of the inverted operand with a carry-in
          bm = (r.alu_op == OP_SUB || r.alu_op == OP_SUBB) ? ~r.operand_b : r.operand_b;
          case (r.alu_op)
            OP_ADDC: cin = cf;
            OP_SUB:  cin = 1'b1;
            OP_SUBB: cin = !cf;
            default: cin = 1'b0;
          endcase
          sum  = {1'b0, r.operand_a} + {1'b0, bm} + {32'b0, cin};
          res  = sum[31:0];
          cout = sum[32];
          ovf  = (r.operand_a[31] == bm[31]) && (r.operand_a[31] != res[31]);
        end
        OP_AND: res = r.operand_a & r.operand_b;
        OP_OR:  res = r.operand_a | r.operand_b;
        OP_XOR: res = r.operand_a ^ r.operand_b;
        OP_SHIFT: begin
          // Signed amount: left for non-negative, logical right for negative
          amt = r.operand_b;
          if (amt > ShiftLimit || amt < -ShiftLimit) begin
            err = 1'b1;
          end else if (amt >= 0) begin
            wide = {32'b0, r.operand_a} << amt;
            res  = wide[31:0];
            cout = wide[32];
          end else begin
            res = r.operand_a >> (-amt);
          end
        end
        default: res = '0;
      endcase
      // Update flags on request; subtract with borrow only ever clears zero
      if (r.set_flags && !err) begin
        if (r.alu_op != OP_SUBB || zf) zf = (res == '0);
        nf = res[31];
        vf = ovf;
        cf = cout;
      end
    end
    o.result            = res;
    o.shift_range_error = err;
    o.flags_now[FLAG_Z] = zf;
    o.flags_now[FLAG_V] = vf;
    o.flags_now[FLAG_N] = nf;
    o.flags_now[FLAG_C] = cf;
    return o;
  endfunction

  // Queue a prediction per accepted item, compare each accepted response
  always @(posedge clk) begin
    if (rst) begin
      zf = 1'b0;
      nf = 1'b0;
      vf = 1'b0;
      cf = 1'b0;
      expected_rsp_q.delete();
    end else begin
      if (req_valid && req_ready) expected_rsp_q.push_back(alu_predict(req));
      if (rsp_valid && rsp_ready) begin
        if (expected_rsp_q.size() == 0) begin
          report_failure($sformatf("response %0d arrived with nothing expected", rsp_index));
        end else begin
          want = expected_rsp_q.pop_front();
          if (rsp.result !== want.result)
            report_failure($sformatf("response %0d: result expected %h, got %h",
                                     rsp_index, want.result, rsp.result));
          if (rsp.branch_taken !== want.branch_taken)
            report_failure($sformatf("response %0d: branch_taken expected %b, got %b",
                                     rsp_index, want.branch_taken, rsp.branch_taken));
          if (rsp.shift_range_error !== want.shift_range_error)
            report_failure($sformatf("response %0d: shift_range_error expected %b, got %b",
                                     rsp_index, want.shift_range_error,
                                     rsp.shift_range_error));
          if (rsp.flags_now !== want.flags_now)
            report_failure($sformatf("response %0d: flags_now expected %b, got %b",
                                     rsp_index, want.flags_now, rsp.flags_now));
        end
        rsp_index++;
      end
    end
    outstanding = expected_rsp_q.size();
  end

endmodule

FILE: tb/alu_flags_branch_condition_tb.sv
// Testbench top for the ALU flag block: clock, reset, item stimulus and verdict.
module alu_flags_branch_condition_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import afbc_pkg::*;

  localparam int RunLimit    = 200000;
  localparam int PhaseItems  = 415;
  localparam int HoldItems   = 30;
  localparam int HoldCycles  = 60;
  localparam int TailCycles  = 10;
  localparam int ResetCycles = 10;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic rsp_ready = 1'b0;
  req_t req       = '0;
  logic req_ready;
  logic rsp_valid;
  rsp_t rsp;

  int   fail_count;
  int   outstanding;
  int   cycle_count   = 0;
  int   send_idle_pct = 0;
  int   stall_pct     = 0;
  logic hold_go       = 1'b0;
  logic hold_seen     = 1'b0;
  int   hold_left     = 0;

  always #6 clk = ~clk;

  alu_flags_branch_condition uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  alu_flags_branch_condition_checker flag_check (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .req         (req),
    .rsp_valid   (rsp_valid),
    .rsp_ready   (rsp_ready),
    .rsp         (rsp),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  // Drive response ready: one long hold-off on request, else random stalls
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else if (hold_go && !hold_seen) begin
      hold_seen <= 1'b1;
      hold_left <= HoldCycles;
      rsp_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RunLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic req_t alu_item(input logic [2:0] op, input logic [31:0] a,
                                    input logic [31:0] b, input logic upd);
    req_t r;
    r           = '0;
    r.command   = CMD_ALU;
    r.alu_op    = op;
    r.operand_a = a;
    r.operand_b = b;
    r.set_flags = upd;
    return r;
  endfunction

  // Condition items carry set_flags high to show it is ignored
  function automatic req_t cond_item(input logic [2:0] code, input logic inv);
    req_t r;
    r                  = '0;
    r.command          = CMD_COND;
    r.set_flags        = 1'b1;
    r.condition_code   = code;
    r.invert_condition = inv;
    return r;
  endfunction

  // Bias operands toward the corners of the 32-bit range
  function automatic logic [31:0] pick_operand();
    case ($urandom_range(9))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h8000_0000;
      3:       return 32'h7FFF_FFFF;
      4:       return $urandom_range(15);
      default: return $urandom;
    endcase
  endfunction

  // Mostly in-range shift amounts, some just or far out of range
  function automatic logic [31:0] pick_shift();
    int amt;
    case ($urandom_range(9))
      0:       amt = $urandom_range(1000, 32);
      1:       amt = -int'($urandom_range(1000, 32));
      2:       amt = $urandom;
      default: amt = int'($urandom_range(62)) - 31;
    endcase
    return amt;
  endfunction

  function automatic req_t random_item();
    req_t r;
    r.command          = ($urandom_range(99) < 30) ? CMD_COND : CMD_ALU;
    r.alu_op           = 3'($urandom_range(7));
    r.operand_a        = pick_operand();
    r.operand_b        = (r.alu_op == OP_SHIFT) ? pick_shift() : pick_operand();
    // Equal operands drive zero results on subtract and xor
    if (r.alu_op != OP_SHIFT && $urandom_range(9) == 0) r.operand_b = r.operand_a;
    r.set_flags        = ($urandom_range(3) != 0);
    r.condition_code   = 3'($urandom_range(7));
    r.invert_condition = 1'($urandom_range(1));
    return r;
  endfunction

  // Offer one item after an optional random gap; hold it until accepted
  task automatic send_item(input req_t item);
    if ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    req_valid <= 1'b1;
    req       <= item;
    do @(posedge clk); while (!req_ready);
  endtask

  // Drop valid and wait for every expected response
  task automatic wait_drained();
    req_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic run_phase(input int idle, input int stall, input int count);
    send_idle_pct = idle;
    stall_pct    <= stall;
    repeat (count) send_item(random_item());
    wait_drained();
  endtask

  initial begin
    repeat (ResetCycles) @(posedge clk);
    rst <= 1'b0;

    // Carry and zero from wrap-around, then conditions on them
    send_item(alu_item(OP_ADD, 32'hFFFF_FFFF, 32'h0000_0001, 1'b1));
    send_item(cond_item(CC_HI, 1'b0));
    send_item(alu_item(OP_ADDC, 32'h0000_0001, 32'h0000_0001, 1'b1));
    // Signed overflow into the sign bit
    send_item(alu_item(OP_ADD, 32'h7FFF_FFFF, 32'h0000_0001, 1'b1));
    send_item(cond_item(CC_GE, 1'b0));
    send_item(cond_item(CC_GT, 1'b1));
    send_item(alu_item(OP_SUB, 32'h0000_0005, 32'h0000_0005, 1'b1));
    send_item(cond_item(CC_NZ, 1'b0));
    // Subtract with borrow: clear zero, then zero stays clear on a zero result
    send_item(alu_item(OP_SUBB, 32'h0000_0000, 32'h0000_0000, 1'b1));
    send_item(alu_item(OP_SUBB, 32'h0000_0007, 32'h0000_0007, 1'b1));
    // Logic operations that set flags clear overflow and carry
    send_item(alu_item(OP_AND, 32'hFFFF_FFFF, 32'h8000_0000, 1'b1));
    send_item(cond_item(CC_NN, 1'b0));
    send_item(alu_item(OP_OR, 32'h0000_0000, 32'h0000_0000, 1'b1));
    send_item(alu_item(OP_XOR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0));
    send_item(cond_item(CC_ALWAYS, 1'b1));
    // Shifts: carry out on left, logical right, amount zero and the range limits
    send_item(alu_item(OP_SHIFT, 32'h8000_0001, 32'h0000_0001, 1'b1));
    send_item(cond_item(CC_NC, 1'b0));
    send_item(alu_item(OP_SHIFT, 32'h0000_0001, 32'h0000_001F, 1'b1));
    send_item(alu_item(OP_SHIFT, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1));
    send_item(alu_item(OP_SHIFT, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1));
    send_item(alu_item(OP_SHIFT, 32'hFFFF_FFFF, 32'hFFFF_FFE1, 1'b1));
    // Out-of-range amounts leave the flags alone
    send_item(alu_item(OP_SHIFT, 32'h0000_0005, 32'h0000_0020, 1'b1));
    send_item(alu_item(OP_SHIFT, 32'h0000_0005, 32'hFFFF_FFE0, 1'b1));
    send_item(alu_item(OP_SHIFT, 32'h0000_0005, 32'h8000_0000, 1'b1));
    send_item(cond_item(CC_NV, 1'b1));
    wait_drained();

    run_phase(0, 0, PhaseItems);
    run_phase(52, 0, PhaseItems);
    run_phase(0, 52, PhaseItems);
    run_phase(34, 34, PhaseItems);

    // Hold the receiver off while items keep coming, so the input stalls
    send_idle_pct = 0;
    stall_pct    <= 0;
    hold_go      <= 1'b1;
    repeat (HoldItems) send_item(random_item());
    wait_drained();

    repeat (TailCycles) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/afbc_pkg.sv
rtl/alu_flags_branch_condition.sv
rtl/afbc_checker.sv
tb/alu_flags_branch_condition_checker.sv
tb/alu_flags_branch_condition_tb.sv
